/* rtl/ttbm_pkg.sv */
// Shared constants and types for the type-tagged byte memory.
`default_nettype none
package ttbm_pkg;

   localparam int MEM_BYTES_DEFAULT = 1024;
   localparam int WORD_BYTES = 4;
   localparam int BANKS = WORD_BYTES;
   localparam int BANK_W = $clog2(BANKS);
   localparam int ADDR_W = 10;
   localparam int DATA_W = 32;
   localparam int BYTE_W = 8;
   localparam int TAG_W = 3;
   localparam int MODE_W = 3;
   localparam int STATUS_W = 2;
   localparam int LIMIT_W = 11;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

   localparam logic [MODE_W-1:0] MODE_WRITE_BYTE = 3'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE_UINT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_WRITE_INT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_READ_BYTE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ_UINT  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_READ_INT   = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SET_TAG    = 3'd6;

   localparam logic [TAG_W-1:0] TAG_BYTE    = 3'd1;
   localparam logic [TAG_W-1:0] TAG_UINT    = 3'd2;
   localparam logic [TAG_W-1:0] TAG_INT     = 3'd3;
   localparam logic [TAG_W-1:0] TAG_IN_UINT = 3'd4;
   localparam logic [TAG_W-1:0] TAG_IN_INT  = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_TYPE = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] write_data;
      logic [TAG_W-1:0]  tag_code;
      logic              addr_bad;
   } op_type;

endpackage
`default_nettype wire

/* rtl/ttbm_front.sv */
// Front end: holds the size register, accepts words and checks their address span.
`default_nettype none
module ttbm_front #(
   parameter int MEM_BYTES = ttbm_pkg::MEM_BYTES_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [ttbm_pkg::MODE_W-1:0]     req_mode,
   input  wire logic [ttbm_pkg::ADDR_W-1:0]     req_address,
   input  wire logic [ttbm_pkg::DATA_W-1:0]     req_write_data,
   input  wire logic [ttbm_pkg::TAG_W-1:0]      req_tag_code,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [ttbm_pkg::LIMIT_W-1:0]    csr_memory_bytes_in_use,
   input  wire logic                            clearing,
   input  wire logic                            queue_full,
   output logic                                 push,
   output ttbm_pkg::op_type                     push_op
);

   localparam int CMP_W = ($clog2(MEM_BYTES + 1) > 12) ? $clog2(MEM_BYTES + 1) : 12;

   logic [ttbm_pkg::LIMIT_W-1:0] limit_ff;
   logic [ttbm_pkg::LIMIT_W-1:0] limit_in;
   logic [CMP_W-1:0]             usable;
   logic [CMP_W-1:0]             span_end;
   logic                         is_word;

   assign csr_ready = 1'b1;
   assign limit_in  = (csr_valid && csr_ready) ? csr_memory_bytes_in_use : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= ttbm_pkg::LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   always_comb begin
      is_word = (req_mode == ttbm_pkg::MODE_WRITE_UINT) || (req_mode == ttbm_pkg::MODE_WRITE_INT)
             || (req_mode == ttbm_pkg::MODE_READ_UINT) || (req_mode == ttbm_pkg::MODE_READ_INT);
      if (CMP_W'(limit_ff) > CMP_W'(MEM_BYTES)) begin
         usable = CMP_W'(MEM_BYTES);
      end else begin
         usable = CMP_W'(limit_ff);
      end
      span_end = CMP_W'(req_address) + (is_word ? CMP_W'(ttbm_pkg::WORD_BYTES) : CMP_W'(1));
   end

   assign req_stall = clearing || queue_full;
   assign push      = req_valid && !req_stall;

   always_comb begin
      push_op.mode       = req_mode;
      push_op.address    = req_address;
      push_op.write_data = req_write_data;
      push_op.tag_code   = req_tag_code;
      push_op.addr_bad   = (req_mode <= ttbm_pkg::MODE_SET_TAG) && (span_end > usable);
   end

endmodule
`default_nettype wire

/* rtl/ttbm_queue.sv */
// Short queue of checked operations between the front end and the memory back end.
`default_nettype none
module ttbm_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire ttbm_pkg::op_type push_op,
   output logic                  full,
   input  wire logic             pop,
   output logic                  pop_valid,
   output ttbm_pkg::op_type      pop_op
);

   localparam int PTR_W = (ttbm_pkg::QUEUE_DEPTH > 1) ? $clog2(ttbm_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(ttbm_pkg::QUEUE_DEPTH + 1);

   ttbm_pkg::op_type   entry_ff [ttbm_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign full      = (count_ff == CNT_W'(ttbm_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_op    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(ttbm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(ttbm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule
`default_nettype wire

/* rtl/ttbm_back.sv */
// Back end: four banked byte and tag memories, the clearing pass and the result stage.
`default_nettype none
module ttbm_back #(
   parameter int MEM_BYTES = ttbm_pkg::MEM_BYTES_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          op_valid,
   input  wire ttbm_pkg::op_type              op,
   output logic                               pop,
   output logic                               clearing,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [ttbm_pkg::DATA_W-1:0]        rsp_read_data,
   output logic [ttbm_pkg::STATUS_W-1:0]      rsp_status
);

   localparam int ROWS  = (MEM_BYTES + ttbm_pkg::BANKS - 1) / ttbm_pkg::BANKS;
   localparam int ROW_W = $clog2(ROWS);
   localparam int SUM_W = (ROW_W + ttbm_pkg::BANK_W > 12) ? ROW_W + ttbm_pkg::BANK_W : 12;
   localparam int BW    = ttbm_pkg::BANK_W;

   logic [ttbm_pkg::BYTE_W-1:0] data_mem [ttbm_pkg::BANKS][ROWS];
   logic [ttbm_pkg::TAG_W-1:0]  tag_mem  [ttbm_pkg::BANKS][ROWS];
   logic [ttbm_pkg::BYTE_W-1:0] rd_data_ff [ttbm_pkg::BANKS];
   logic [ttbm_pkg::TAG_W-1:0]  rd_tag_ff  [ttbm_pkg::BANKS];

   logic [ROW_W-1:0]             row      [ttbm_pkg::BANKS];
   logic                         data_we  [ttbm_pkg::BANKS];
   logic                         tag_we   [ttbm_pkg::BANKS];
   logic [ttbm_pkg::BYTE_W-1:0]  data_wv  [ttbm_pkg::BANKS];
   logic [ttbm_pkg::TAG_W-1:0]   tag_wv   [ttbm_pkg::BANKS];

   logic                         clear_ff;
   logic                         clear_in;
   logic [ROW_W-1:0]             clr_row_ff;
   logic [ROW_W-1:0]             clr_row_in;
   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   logic [ttbm_pkg::MODE_W-1:0]  s1_mode_ff;
   logic [BW-1:0]                s1_off_ff;
   logic                         s1_bad_ff;

   logic [BW-1:0]                off;
   logic                         is_word_write;
   logic [ttbm_pkg::TAG_W-1:0]   head_tag;
   logic [ttbm_pkg::TAG_W-1:0]   inner_tag;
   logic [ttbm_pkg::DATA_W-1:0]  word;
   logic [ttbm_pkg::TAG_W-1:0]   head_read;

   assign clearing = clear_ff;
   assign pop      = op_valid && !clear_ff && (!s1_valid_ff || !rsp_stall);
   assign off      = op.address[BW-1:0];

   always_comb begin
      is_word_write = (op.mode == ttbm_pkg::MODE_WRITE_UINT) || (op.mode == ttbm_pkg::MODE_WRITE_INT);
      head_tag      = (op.mode == ttbm_pkg::MODE_WRITE_INT) ? ttbm_pkg::TAG_INT : ttbm_pkg::TAG_UINT;
      inner_tag     = (op.mode == ttbm_pkg::MODE_WRITE_INT) ? ttbm_pkg::TAG_IN_INT
                                                            : ttbm_pkg::TAG_IN_UINT;
   end

   always_comb begin
      logic [BW-1:0]    j;
      logic [SUM_W-1:0] lane_sum;
      logic [ttbm_pkg::DATA_W-1:0] shifted;
      for (int b = 0; b < ttbm_pkg::BANKS; b++) begin
         j        = BW'(b) - off;
         lane_sum = SUM_W'(op.address) + SUM_W'(j);
         shifted  = op.write_data >> {j, 3'b000};
         if (clear_ff) begin
            row[b]     = clr_row_ff;
            data_we[b] = 1'b1;
            tag_we[b]  = 1'b1;
            data_wv[b] = '0;
            tag_wv[b]  = '0;
         end else begin
            row[b]     = lane_sum[ROW_W+BW-1:BW];
            data_wv[b] = shifted[ttbm_pkg::BYTE_W-1:0];
            tag_wv[b]  = (j == '0) ? head_tag : inner_tag;
            data_we[b] = 1'b0;
            tag_we[b]  = 1'b0;
            if (pop && !op.addr_bad) begin
               if (is_word_write) begin
                  data_we[b] = 1'b1;
                  tag_we[b]  = 1'b1;
               end else if (j == '0) begin
                  if (op.mode == ttbm_pkg::MODE_WRITE_BYTE) begin
                     data_we[b] = 1'b1;
                     tag_we[b]  = 1'b1;
                     tag_wv[b]  = ttbm_pkg::TAG_BYTE;
                  end else if (op.mode == ttbm_pkg::MODE_SET_TAG) begin
                     tag_we[b]  = 1'b1;
                     tag_wv[b]  = op.tag_code;
                  end
               end
            end
         end
      end
   end

   for (genvar g = 0; g < ttbm_pkg::BANKS; g++) begin : g_bank
      always_ff @(posedge clock) begin
         if (data_we[g]) begin
            data_mem[g][row[g]] <= data_wv[g];
         end
         if (tag_we[g]) begin
            tag_mem[g][row[g]] <= tag_wv[g];
         end
         if (pop) begin
            rd_data_ff[g] <= data_mem[g][row[g]];
            rd_tag_ff[g]  <= tag_mem[g][row[g]];
         end
      end
   end

   always_comb begin
      clear_in   = clear_ff;
      clr_row_in = clr_row_ff;
      if (clear_ff) begin
         clr_row_in = clr_row_ff + 1'b1;
         if (clr_row_ff == ROW_W'(ROWS - 1)) begin
            clear_in = 1'b0;
         end
      end
      s1_valid_in = pop || (s1_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_row_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         clear_ff    <= clear_in;
         clr_row_ff  <= clr_row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_mode_ff <= op.mode;
         s1_off_ff  <= off;
         s1_bad_ff  <= op.addr_bad;
      end
   end

   always_comb begin
      logic [BW-1:0] k;
      for (int j = 0; j < ttbm_pkg::BANKS; j++) begin
         k = s1_off_ff + BW'(j);
         word[j*ttbm_pkg::BYTE_W +: ttbm_pkg::BYTE_W] = rd_data_ff[k];
      end
      head_read     = rd_tag_ff[s1_off_ff];
      rsp_read_data = '0;
      rsp_status    = ttbm_pkg::STATUS_OK;
      if (s1_bad_ff) begin
         rsp_status = ttbm_pkg::STATUS_BAD_ADDR;
      end else begin
         unique case (s1_mode_ff)
            ttbm_pkg::MODE_READ_BYTE: begin
               if (head_read != ttbm_pkg::TAG_BYTE) begin
                  rsp_status = ttbm_pkg::STATUS_BAD_TYPE;
               end else begin
                  rsp_read_data = ttbm_pkg::DATA_W'(word[ttbm_pkg::BYTE_W-1:0]);
               end
            end
            ttbm_pkg::MODE_READ_UINT: begin
               if (head_read != ttbm_pkg::TAG_UINT) begin
                  rsp_status = ttbm_pkg::STATUS_BAD_TYPE;
               end else begin
                  rsp_read_data = word;
               end
            end
            ttbm_pkg::MODE_READ_INT: begin
               if (head_read != ttbm_pkg::TAG_INT) begin
                  rsp_status = ttbm_pkg::STATUS_BAD_TYPE;
               end else begin
                  rsp_read_data = word;
               end
            end
            default: begin
               rsp_read_data = '0;
            end
         endcase
      end
   end

   assign rsp_valid = s1_valid_ff;

endmodule
`default_nettype wire

/* rtl/type_tagged_byte_memory.sv */
// Top level of the type-tagged byte memory.
// Usage: a request word on the req_ channel names an operation, an address, write data
// and a tag. Every request gives exactly one response word on the rsp_ channel, with
// read data and a status, in request order. The csr_ channel sets the number of bytes
// in use and is always ready; write it only while no request is outstanding.
// An accepted request passes first through the queue and then through the banked memory
// read, after which the response is shown from registers. Throughput is one word per
// cycle while rsp_stall is low and no clearing pass runs, set by the single access per
// cycle to the four byte-wide banks. After reset the block clears all data and tag bytes,
// one row of four bytes per cycle; req_stall stays high during that pass. When rsp_stall
// is high the response holds, the back end stops, the two-entry queue fills and then
// req_stall rises.
`default_nettype none
module type_tagged_byte_memory #(
   parameter int MEM_BYTES = ttbm_pkg::MEM_BYTES_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [ttbm_pkg::MODE_W-1:0]   req_mode,
   input  wire logic [ttbm_pkg::ADDR_W-1:0]   req_address,
   input  wire logic [ttbm_pkg::DATA_W-1:0]   req_write_data,
   input  wire logic [ttbm_pkg::TAG_W-1:0]    req_tag_code,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [ttbm_pkg::DATA_W-1:0]        rsp_read_data,
   output logic [ttbm_pkg::STATUS_W-1:0]      rsp_status,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [ttbm_pkg::LIMIT_W-1:0]  csr_memory_bytes_in_use
);

   logic             clearing;
   logic             queue_full;
   logic             push;
   ttbm_pkg::op_type push_op;
   logic             pop;
   logic             pop_valid;
   ttbm_pkg::op_type pop_op;

   ttbm_front #(.MEM_BYTES(MEM_BYTES)) u_front (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_mode                (req_mode),
      .req_address             (req_address),
      .req_write_data          (req_write_data),
      .req_tag_code            (req_tag_code),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_memory_bytes_in_use (csr_memory_bytes_in_use),
      .clearing                (clearing),
      .queue_full              (queue_full),
      .push                    (push),
      .push_op                 (push_op)
   );

   ttbm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_op   (push_op),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_op    (pop_op)
   );

   ttbm_back #(.MEM_BYTES(MEM_BYTES)) u_back (
      .clock         (clock),
      .reset         (reset),
      .op_valid      (pop_valid),
      .op            (pop_op),
      .pop           (pop),
      .clearing      (clearing),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_read_data (rsp_read_data),
      .rsp_status    (rsp_status)
   );

endmodule
`default_nettype wire
